// File: hdl/swk_pkg.sv
package swk_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK        = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd3;
  localparam logic [CFG_W-1:0] RANK_RST        = 7'd2;

  // flips two's complement into an order-preserving unsigned key
  localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic go;
    logic ack;
  } swk_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } swk_stat_t;

endpackage

// File: hdl/sliding_window_kth_smallest.sv
// After a sample that completes a window is accepted, each of the 32 key bits
// takes a scan of the newest w samples, w being the effective window size, and
// a decision step; result_valid then rises with the result. A stalled result holds
// the engine, and with it the input, until it is taken.
// No new sample is taken while a selection runs; a sample that leaves the
// window short starts none. Reset empties the window, loads 3 and 2, no clear.
module sliding_window_kth_smallest #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [swk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swk_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [31:0]             sample,
  input  logic                           start_of_sequence,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [31:0]             kth_value
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int EW = (CW > swk_pkg::CFG_W) ? CW : swk_pkg::CFG_W;

  logic [swk_pkg::CFG_W-1:0]  window_size;
  logic [swk_pkg::CFG_W-1:0]  rank;
  logic [EW-1:0]              ws_ext;
  logic [EW-1:0]              rk_ext;
  logic [EW-1:0]              w_wide;
  logic [EW-1:0]              k_wide;
  logic [CW-1:0]              w_eff;
  logic [CW-1:0]              k_eff;
  logic                       accept;
  logic                       load;
  logic [CW-1:0]              fill_after;
  logic [AW-1:0]              wr_ptr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [swk_pkg::DATA_W-1:0] rd_data;
  logic [swk_pkg::DATA_W-1:0] result;
  swk_pkg::swk_ctrl_t         ctrl;
  swk_pkg::swk_stat_t         stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swk_pkg::WINDOW_SIZE_RST;
      rank        <= swk_pkg::RANK_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        swk_pkg::REG_WINDOW_SIZE: window_size <= cfg_data;
        swk_pkg::REG_RANK:        rank        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ws_ext = EW'(window_size);
    rk_ext = EW'(rank);
    if (ws_ext == '0) begin
      w_wide = EW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      w_wide = EW'(WINDOW_MAX);
    end else begin
      w_wide = ws_ext;
    end
    if (rk_ext == '0) begin
      k_wide = EW'(1);
    end else if (rk_ext > w_wide) begin
      k_wide = w_wide;
    end else begin
      k_wide = rk_ext;
    end
    w_eff = w_wide[CW-1:0];
    k_eff = k_wide[CW-1:0];
  end

  assign sample_stall = !stat.idle;
  assign accept       = sample_valid && !sample_stall;
  assign ctrl.go      = accept && (fill_after >= w_eff);
  assign load         = stat.done && (!result_valid || !result_stall);
  assign ctrl.ack     = load;

  swk_window #(
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW),
    .CW         (CW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept),
    .restart    (start_of_sequence),
    .wr_data    (sample),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_ptr     (wr_ptr),
    .fill_after (fill_after)
  );

  swk_select #(
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW),
    .CW         (CW)
  ) u_select (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .wlen_in (w_eff),
    .k_in    (k_eff),
    .newest  (wr_ptr),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      kth_value    <= result;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stat.done))
    else $error("result raised without a finished selection");

  a_new_sequence_no_run: assert property (@(posedge clk) disable iff (rst)
    (accept && start_of_sequence && (w_eff > CW'(1))) |=> stat.idle)
    else $error("selection started on a fresh sequence with a short window");

  a_stat_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({stat.idle, stat.done}))
    else $error("engine idle and done at once");

endmodule

// File: hdl/swk_window.sv
module swk_window #(
  parameter int WINDOW_MAX = 64,
  parameter int AW         = $clog2(WINDOW_MAX),
  parameter int CW         = $clog2(WINDOW_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic                        restart,
  input  logic [swk_pkg::DATA_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [swk_pkg::DATA_W-1:0]  rd_data,
  output logic [AW-1:0]               wr_ptr,
  output logic [CW-1:0]               fill_after
);

  logic [swk_pkg::DATA_W-1:0] mem [WINDOW_MAX];
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_base;

  always_comb begin
    fill_base = restart ? '0 : fill;
    if (fill_base == CW'(WINDOW_MAX)) begin
      fill_after = fill_base;
    end else begin
      fill_after = fill_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      fill   <= '0;
    end else if (wr_en) begin
      fill <= fill_after;
      if (wr_ptr == AW'(WINDOW_MAX - 1)) begin
        wr_ptr <= '0;
      end else begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/swk_select.sv
// Bit-serial radix selection, MSB first: one pass over the window per key bit.
module swk_select #(
  parameter int WINDOW_MAX = 64,
  parameter int AW         = $clog2(WINDOW_MAX),
  parameter int CW         = $clog2(WINDOW_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  swk_pkg::swk_ctrl_t          ctrl,
  input  logic [CW-1:0]               wlen_in,
  input  logic [CW-1:0]               k_in,
  input  logic [AW-1:0]               newest,
  input  logic [swk_pkg::DATA_W-1:0]  rd_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output swk_pkg::swk_stat_t          stat,
  output logic [swk_pkg::DATA_W-1:0]  result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t                     state;
  logic [AW-1:0]              addr;
  logic [AW-1:0]              base;
  logic [CW-1:0]              left;
  logic [CW-1:0]              wlen;
  logic [CW-1:0]              c0;
  logic [CW-1:0]              krem;
  logic [swk_pkg::DATA_W-1:0] bitsel;
  logic [swk_pkg::DATA_W-1:0] mask;
  logic [swk_pkg::DATA_W-1:0] prefix;
  logic                       pv;
  logic [swk_pkg::DATA_W-1:0] key;
  logic                       cand;
  logic                       zero;
  logic [AW-1:0]              addr_next;

  assign key       = rd_data ^ swk_pkg::SIGN_FLIP;
  assign cand      = ((key ^ prefix) & mask) == '0;
  assign zero      = (key & bitsel) == '0;
  assign addr_next = (addr == '0) ? AW'(WINDOW_MAX - 1) : addr - 1'b1;

  assign rd_en     = (state == S_SCAN) && (left != '0);
  assign rd_addr   = addr;
  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign result    = prefix ^ swk_pkg::SIGN_FLIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
    end else begin
      pv <= rd_en;
      case (state)
        S_IDLE: begin
          if (ctrl.go) begin
            wlen   <= wlen_in;
            krem   <= k_in;
            base   <= newest;
            addr   <= newest;
            left   <= wlen_in;
            c0     <= '0;
            bitsel <= {1'b1, {(swk_pkg::DATA_W-1){1'b0}}};
            mask   <= '0;
            prefix <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            addr <= addr_next;
            left <= left - 1'b1;
          end
          if (pv && cand && zero) begin
            c0 <= c0 + 1'b1;
          end
          if (pv && (left == '0)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (krem > c0) begin
            prefix <= prefix | bitsel;
            krem   <= krem - c0;
          end
          mask   <= mask | bitsel;
          bitsel <= bitsel >> 1;
          c0     <= '0;
          left   <= wlen;
          addr   <= base;
          if (bitsel[0]) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (ctrl.ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: bench/tb_top.sv
class rank_window #(int DEPTH = 64);
  logic signed [31:0] samples[DEPTH];
  int fill = 0;
  logic [swk_pkg::CFG_W-1:0] size_reg = swk_pkg::WINDOW_SIZE_RST;
  logic [swk_pkg::CFG_W-1:0] rank_reg = swk_pkg::RANK_RST;
  logic signed [31:0] expected_kth[$];
  int unsigned errors = 0;

  function void set_reg(logic [swk_pkg::CFG_IDX_W-1:0] idx, logic [swk_pkg::CFG_W-1:0] val);
    if (idx == swk_pkg::REG_WINDOW_SIZE) begin
      size_reg = val;
    end else if (idx == swk_pkg::REG_RANK) begin
      rank_reg = val;
    end
  endfunction

  // shift the sample in and, once w samples are held, queue the rank-th smallest of the newest w samples
  function void take_sample(logic signed [31:0] value, logic sos);
    logic signed [31:0] sorted[DEPTH];
    logic signed [31:0] tmp;
    int w, k, i, j;
    if (sos) fill = 0;
    for (i = DEPTH - 1; i > 0; i--) samples[i] = samples[i-1];
    samples[0] = value;
    if (fill < DEPTH) fill++;
    w = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : int'(size_reg);
    k = (rank_reg == 0) ? 1 : (int'(rank_reg) > w) ? w : int'(rank_reg);
    if (fill < w) return;
    for (i = 0; i < w; i++) begin
      tmp = samples[i];
      j = i;
      while (j > 0 && sorted[j-1] > tmp) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = tmp;
    end
    expected_kth.push_back(sorted[k-1]);
  endfunction

  function void check_kth(logic signed [31:0] got);
    logic signed [31:0] want;
    if (expected_kth.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: kth_value %0d", got);
      return;
    end
    want = expected_kth.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("kth_value wrong: expected %0d, got %0d", want, got);
    end
  endfunction

  function int pending();
    return expected_kth.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX = 64;
  localparam int ITEMS   = 1400;
  localparam int SETTLE  = 32 * (WIN_MAX + 2) + 8;
  localparam int LIMIT   = 20_000_000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [swk_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [swk_pkg::CFG_W-1:0]       cfg_data = '0;
  logic                            sample_valid = 1'b0;
  logic                            sample_stall;
  logic signed [31:0]              sample = '0;
  logic                            start_of_sequence = 1'b0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic signed [31:0]              kth_value;

  rank_window #(WIN_MAX) rw;
  bit src_idle = 1'b1;
  bit dst_idle = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  sliding_window_kth_smallest #(.WINDOW_MAX(WIN_MAX)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .start_of_sequence(start_of_sequence),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kth_value(kth_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("sliding_window_kth_smallest: mismatch");
      $finish;
    end
  end

  // result side: after each result is taken, while dst_idle is set, the next is held off for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (result_valid && !result_stall) begin
      rw.check_kth(kth_value);
      stall_left = dst_idle ? $urandom_range(0, 13) : 0;
      result_stall <= (stall_left != 0);
    end else if (result_valid && stall_left != 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) result_stall <= 1'b0;
    end
  end

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(logic signed [31:0] value, logic sos);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    start_of_sequence <= sos;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    rw.take_sample(value, sos);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (rw.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [swk_pkg::CFG_W-1:0] ws, logic [swk_pkg::CFG_W-1:0] rk);
    cfg_write <= 1'b1;
    cfg_index <= swk_pkg::REG_WINDOW_SIZE;
    cfg_data <= ws;
    @(posedge clk);
    rw.set_reg(swk_pkg::REG_WINDOW_SIZE, ws);
    cfg_index <= swk_pkg::REG_RANK;
    cfg_data <= rk;
    @(posedge clk);
    rw.set_reg(swk_pkg::REG_RANK, rk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned sent, n, ws, rk, phase, i;
    bit wide, sos;
    rw = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window 3, rank 2
    send(32'sh7fff_ffff, 1'b0);
    send(32'sh8000_0000, 1'b0);
    send(-32'sd1, 1'b0);
    send(32'sd0, 1'b0);
    send(32'sd0, 1'b0);
    send(32'sd5, 1'b1);
    send(32'sd5, 1'b0);
    send(32'sd5, 1'b0);
    settle();
    // zero window and zero rank behave as 1
    write_cfg(7'd0, 7'd0);
    send(32'sh8000_0000, 1'b0);
    send(32'sh7fff_ffff, 1'b0);
    send(-32'sd7, 1'b1);
    settle();
    // rank above window size
    write_cfg(7'd5, 7'd9);
    send(32'sd3, 1'b1);
    send(-32'sd3, 1'b0);
    send(32'sd3, 1'b0);
    send(32'sh8000_0000, 1'b0);
    send(32'sd3, 1'b0);
    send(32'sh7fff_ffff, 1'b0);
    settle();
    // change mid-sequence
    write_cfg(7'd2, 7'd127);
    send(32'sd1, 1'b0);
    send(-32'sd2, 1'b0);
    settle();
    write_cfg(7'd4, 7'd3);
    send(32'sd9, 1'b0);
    send(-32'sd9, 1'b0);
    send(32'sd9, 1'b0);

    sent = 0;
    phase = 0;
    while (sent < ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      dst_idle = ($urandom_range(0, 3) != 0);
      wide = (phase % 9 == 4);
      if (wide) begin
        case ((phase / 9) % 3)
          0: begin ws = 127; rk = 127; end
          1: begin ws = WIN_MAX; rk = 1; end
          default: begin ws = WIN_MAX; rk = $urandom_range(0, 127); end
        endcase
        n = WIN_MAX + $urandom_range(1, 5);
      end else begin
        ws = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
        rk = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, ws + 1);
        n = $urandom_range(20, 60);
      end
      settle();
      write_cfg(ws[swk_pkg::CFG_W-1:0], rk[swk_pkg::CFG_W-1:0]);
      for (i = 0; i < n; i++) begin
        if (i == 0) sos = wide || ($urandom_range(0, 1) == 1);
        else sos = !wide && ($urandom_range(0, 31) == 0);
        send(pick_sample(), sos);
        sent++;
      end
      phase++;
    end

    settle();
    if (rw.errors == 0 && rw.pending() == 0) begin
      $display("sliding_window_kth_smallest: match");
    end else begin
      $display("sliding_window_kth_smallest: mismatch");
    end
    $finish;
  end
endmodule
